@@ sv/tone_generator_with_fade_envelope_unit_defines.svh @@
// Assertion shorthands for the tone generator checks.
// Both expect clk and rst to be visible where they are used.
`ifndef TONE_GENERATOR_WITH_FADE_ENVELOPE_UNIT_DEFINES_SVH
`define TONE_GENERATOR_WITH_FADE_ENVELOPE_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGFE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tone generator check failed");

// Consequent must hold in the cycle after the antecedent.
`define TGFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tone generator check failed");

`endif

@@ sv/tgfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tgfe_pkg;

  localparam int NOTE_LEN_W = 20;
  localparam int FADE_W     = 12;
  localparam int VOL_W      = 15;
  localparam int ADDR_W     = 3;
  localparam int DIV_STEPS  = 16;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic REG_VOLUME = 1'b0;
  localparam logic REG_FADE   = 1'b1;

  localparam logic [VOL_W-1:0]  VOLUME_RESET = 15'd3277;
  localparam logic [FADE_W-1:0] FADE_RESET   = 12'd275;

  localparam logic [14:0] COEF_FUND   = 15'd25559;
  localparam logic [14:0] COEF_SECOND = 15'd3932;
  localparam logic [17:0] ENV_ONE     = 18'd65536;

  localparam logic [16:0] SAT_POS     = 17'd32767;
  localparam logic [16:0] SAT_NEG_MAG = 17'd32768;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef struct packed {
    logic                  req_type;
    logic [31:0]           phase_step;
    logic [NOTE_LEN_W-1:0] note_length;
  } tgfe_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_of_note;
    logic               idle;
  } tgfe_out_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    logic               mul_en;
    logic signed [30:0] mul_a;
    logic signed [17:0] mul_b;
    acc_op_t            acc_op;
    logic               div_init;
    logic               div_step;
    logic [FADE_W-1:0]  div_num;
    logic [FADE_W-1:0]  div_den;
  } tgfe_alu_ctl_t;

endpackage

`default_nettype wire

@@ sv/tgfe_sine_rom.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tgfe_sine_rom import tgfe_pkg::*; #(
  parameter int SINE_ENTRIES = 1024
) (
  input  wire logic               clk,
  input  wire logic [31:0]        phase,
  output logic signed [15:0]      data
);

  localparam int IDX_W = $clog2(SINE_ENTRIES);
  localparam int PW    = 32 + IDX_W;

  typedef logic signed [15:0] rom_t [SINE_ENTRIES];

  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    logic [1:0]  quad;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      t    = (64'(k) << 32) / SINE_ENTRIES;
      quad = t[31:30];
      r    = t & (ONE_Q30 - 64'd1);
      u    = quad[0] ? (ONE_Q30 - r) : r;
      a    = (u * HALF_PI_Q30) >> 30;
      term = a;
      sum  = a;
      for (int i = 0; i < 8; i++) begin
        term = ((((term * a) >> 30) * a) >> 30) / TAYLOR_DIV[i];
        if (i[0] == 1'b0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      mag = (sum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      tbl[k] = quad[1] ? (16'd0 - mag[15:0]) : mag[15:0];
    end
    return tbl;
  endfunction

  localparam rom_t ROM_DATA = build_rom();

  logic [PW-1:0]    scaled;
  logic [IDX_W-1:0] idx;

  assign scaled = PW'(phase) * PW'(SINE_ENTRIES);
  assign idx    = scaled[32 +: IDX_W];

  always_ff @(posedge clk) begin
    data <= ROM_DATA[idx];
  end

endmodule

`default_nettype wire

@@ sv/tgfe_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tgfe_alu import tgfe_pkg::*; (
  input  wire logic          clk,
  input  wire tgfe_alu_ctl_t ctl,
  output logic signed [63:0] acc,
  output logic [15:0]        quo
);

  logic signed [48:0] prod;
  logic signed [63:0] acc_next;
  logic [FADE_W-1:0]  rem;
  logic [FADE_W-1:0]  den;
  logic [FADE_W+1:0]  trial;

  always_comb begin
    case (ctl.acc_op)
      ACC_LOAD:   acc_next = 64'(prod);
      ACC_ADD:    acc_next = acc + 64'(prod);
      ACC_ADD_HI: acc_next = acc + (64'(prod) <<< 23);
      default:    acc_next = acc;
    endcase
  end

  assign trial = {1'b0, rem, 1'b0} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= ctl.mul_a * ctl.mul_b;
    end
    acc <= acc_next;
    if (ctl.div_init) begin
      rem <= ctl.div_num;
      den <= ctl.div_den;
      quo <= '0;
    end else if (ctl.div_step) begin
      if (!trial[FADE_W+1]) begin
        rem <= trial[FADE_W-1:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= {rem[FADE_W-2:0], 1'b0};
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/tone_generator_with_fade_envelope_unit.sv @@
// Note-driven tone generator with a linear fade envelope.
// cmd channel: a start beat (req_type 0) loads the phase step and the note length and
// clears phase and sample index; it returns nothing and the FSM stays idle. A tick beat
// (req_type 1) returns one res beat: a signed sample, the last-of-note flag and the
// idle flag. Volume and fade length are written over the APB port (0x0, 0x4).
// A tick after note end or during a rest goes straight to S_OUT. A sounding sample at
// full envelope passes S_RD1, S_RD2, S_MIX1, S_MIX2, S_ABS, S_MVOL, S_PV, S_ML, S_MH
// and S_ADDH in that order; a sample inside a fade first passes S_DIV, where the
// envelope quotient is formed one bit per cycle. The next beat can be taken in the
// cycle after the result is registered. All products go through one shared 31x18
// multiplier and accumulator; the two sine lookups share the single ROM read port.
// The block takes one beat at a time: cmd_stall is high while a tick is in progress.
// A finished result waits in the output register while res_stall is high, and a new
// beat may be accepted meanwhile; a following result waits until the register frees.
// Synchronous reset clears the note state, restores volume 3277 and fade 275 and
// empties the output register.

`timescale 1ns / 1ps
`default_nettype none

module tone_generator_with_fade_envelope_unit import tgfe_pkg::*; #(
  parameter int SINE_ENTRIES = 1024,
  parameter int LENGTH_BITS  = 20
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire tgfe_in_t          cmd,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output tgfe_out_t              res
);

  localparam int CMP_W = (LENGTH_BITS > FADE_W) ? LENGTH_BITS : FADE_W;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_DIV  = 13'b0000000000010,
    S_RD1  = 13'b0000000000100,
    S_RD2  = 13'b0000000001000,
    S_MIX1 = 13'b0000000010000,
    S_MIX2 = 13'b0000000100000,
    S_ABS  = 13'b0000001000000,
    S_MVOL = 13'b0000010000000,
    S_PV   = 13'b0000100000000,
    S_ML   = 13'b0001000000000,
    S_MH   = 13'b0010000000000,
    S_ADDH = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [VOL_W-1:0]        volume;
  logic [FADE_W-1:0]       fade_samples;
  logic [31:0]             phase_acc;
  logic [31:0]             step_reg;
  logic [LENGTH_BITS-1:0]  sample_index;
  logic [LENGTH_BITS-1:0]  length_reg;
  logic [3:0]              div_cnt;
  logic                    env_div;
  logic                    use_mix;
  logic                    advance;
  logic                    res_last;
  logic                    res_idle;
  logic                    neg;
  logic [29:0]             mixmag;

  logic                    cfg_write;
  logic                    cmd_take;
  logic                    out_free;
  logic [LENGTH_BITS-1:0]  len_in;
  logic [LENGTH_BITS-1:0]  remain;
  logic                    near_end;
  logic                    near_start;
  logic [31:0]             rom_phase;
  logic signed [15:0]      rom_data;
  tgfe_alu_ctl_t           ctl;
  logic signed [63:0]      acc;
  logic [15:0]             quo;
  logic [17:0]             env_b;
  logic [63:0]             acc_abs;
  logic [16:0]             mag;
  logic [16:0]             neg_val;
  logic [15:0]             sample_val;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;
  assign len_in    = LENGTH_BITS'(cmd.note_length);

  always_comb begin
    if (paddr[2] == REG_FADE) begin
      prdata = 32'(fade_samples);
    end else begin
      prdata = 32'(volume);
    end
  end

  assign remain     = length_reg - sample_index;
  assign near_end   = CMP_W'(remain) < CMP_W'(fade_samples);
  assign near_start = CMP_W'(sample_index) < CMP_W'(fade_samples);
  assign rom_phase  = (state == S_RD2) ? (phase_acc << 1) : phase_acc;
  assign env_b      = env_div ? {2'b00, quo} : ENV_ONE;
  assign acc_abs    = acc[63] ? (64'd0 - acc) : acc;
  assign mag        = acc[62:46];
  assign neg_val    = 17'd0 - mag;

  always_comb begin
    if (!use_mix) begin
      sample_val = '0;
    end else if (neg) begin
      sample_val = (mag > SAT_NEG_MAG) ? 16'h8000 : neg_val[15:0];
    end else begin
      sample_val = (mag > SAT_POS) ? 16'h7fff : mag[15:0];
    end
  end

  tgfe_sine_rom #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .phase(rom_phase),
    .data (rom_data)
  );

  tgfe_alu u_alu (
    .clk(clk),
    .ctl(ctl),
    .acc(acc),
    .quo(quo)
  );

  always_comb begin
    ctl         = '0;
    ctl.acc_op  = ACC_HOLD;
    ctl.div_den = fade_samples;
    ctl.div_num = near_end ? FADE_W'(remain) : FADE_W'(sample_index);
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_take && cmd.req_type == REQ_TICK) begin
          ctl.div_init = 1'b1;
          if (sample_index >= length_reg || step_reg == '0) begin
            state_next = S_OUT;
          end else if (fade_samples != '0 && (near_end || near_start)) begin
            state_next = S_DIV;
          end else begin
            state_next = S_RD1;
          end
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (div_cnt == 4'(DIV_STEPS - 1)) begin
          state_next = S_RD1;
        end
      end
      S_RD1: begin
        state_next = S_RD2;
      end
      S_RD2: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = 31'(rom_data);
        ctl.mul_b  = 18'(COEF_FUND);
        state_next = S_MIX1;
      end
      S_MIX1: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = 31'(rom_data);
        ctl.mul_b  = 18'(COEF_SECOND);
        ctl.acc_op = ACC_LOAD;
        state_next = S_MIX2;
      end
      S_MIX2: begin
        ctl.acc_op = ACC_ADD;
        state_next = S_ABS;
      end
      S_ABS: begin
        state_next = S_MVOL;
      end
      S_MVOL: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = 31'(mixmag);
        ctl.mul_b  = 18'(volume);
        state_next = S_PV;
      end
      S_PV: begin
        ctl.acc_op = ACC_LOAD;
        state_next = S_ML;
      end
      S_ML: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = 31'(acc[22:0]);
        ctl.mul_b  = env_b;
        state_next = S_MH;
      end
      S_MH: begin
        ctl.mul_en = 1'b1;
        ctl.mul_a  = 31'(acc[44:23]);
        ctl.mul_b  = env_b;
        ctl.acc_op = ACC_LOAD;
        state_next = S_ADDH;
      end
      S_ADDH: begin
        ctl.acc_op = ACC_ADD_HI;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      volume       <= VOLUME_RESET;
      fade_samples <= FADE_RESET;
      phase_acc    <= '0;
      step_reg     <= '0;
      sample_index <= '0;
      length_reg   <= '0;
      div_cnt      <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (paddr[2] == REG_FADE) begin
          fade_samples <= pwdata[FADE_W-1:0];
        end else begin
          volume <= pwdata[VOL_W-1:0];
        end
      end
      if (cmd_take && cmd.req_type == REQ_START) begin
        step_reg     <= cmd.phase_step;
        length_reg   <= len_in;
        phase_acc    <= '0;
        sample_index <= '0;
      end
      if (state == S_IDLE) begin
        div_cnt <= '0;
      end else if (state == S_DIV) begin
        div_cnt <= div_cnt + 4'd1;
      end
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
        if (advance) begin
          sample_index <= sample_index + 1'b1;
          phase_acc    <= phase_acc + step_reg;
        end
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_take) begin
      env_div  <= fade_samples != '0 && (near_end || near_start);
      use_mix  <= sample_index < length_reg && step_reg != '0;
      advance  <= sample_index < length_reg;
      res_idle <= sample_index >= length_reg;
      res_last <= sample_index < length_reg
                  && LENGTH_BITS'(sample_index + 1'b1) == length_reg;
    end
    if (state == S_ABS) begin
      neg    <= acc[63];
      mixmag <= acc_abs[29:0];
    end
    if (state == S_OUT && out_free) begin
      res.sample       <= sample_val;
      res.last_of_note <= res_last;
      res.idle         <= res_idle;
    end
  end

endmodule

`default_nettype wire

@@ sv/tgfe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "tone_generator_with_fade_envelope_unit_defines.svh"

module tgfe_checker import tgfe_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      cmd_valid,
  input wire logic      cmd_stall,
  input wire tgfe_in_t  cmd,
  input wire logic      res_valid,
  input wire logic      res_stall,
  input wire tgfe_out_t res
);

  `TGFE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
  `TGFE_ASSERT_NEXT(a_start_one_cycle, cmd_valid && !cmd_stall && cmd.req_type == REQ_START, !cmd_stall)
  `TGFE_ASSERT_NEXT(a_tick_busy, cmd_valid && !cmd_stall && cmd.req_type == REQ_TICK, cmd_stall)
  `TGFE_ASSERT_SAME(a_reset_empty, $past(rst), !res_valid && !cmd_stall)

endmodule

bind tone_generator_with_fade_envelope_unit tgfe_checker u_checker (.*);

`default_nettype wire
